// ----- rtl/kass_pkg.sv -----
package kass_pkg;

	// field and state widths
	localparam int KEY_W      = 4;
	localparam int ANGLE_W    = 14;
	localparam int STEPS_W    = 17;
	localparam int PHASE_W    = 3;
	localparam int COIL_W     = 4;
	localparam int IN_DATA_W  = 8;
	localparam int IN_USER_W  = 1;
	localparam int OUT_DATA_W = 24;

	// default digit limit for the top level
	localparam int MAX_DIGITS_DEF = 4;

	// saturation limits
	localparam logic [ANGLE_W-1:0] ANGLE_MAX = '1;
	localparam logic [STEPS_W-1:0] STEPS_MAX = '1;

	// item kinds carried in tuser
	typedef enum logic {
		REQ_TICK = 1'b0,
		REQ_KEY  = 1'b1
	} req_type_t;

	// key codes
	localparam logic [KEY_W-1:0] KEY_DIGIT_MAX = 4'd9;
	localparam logic [KEY_W-1:0] KEY_STAR      = 4'd10;
	localparam logic [KEY_W-1:0] KEY_HASH      = 4'd11;

	// floor(y / 45) as (y * RECIP_MULT) >> RECIP_SHIFT, exact for y below 2^24 / 44
	localparam int              RECIP_SHIFT = 24;
	localparam int              RECIP_W     = 19;
	localparam logic [RECIP_W-1:0] RECIP_MULT = 19'd372828;

	// reverse half-step coil sequence
	function automatic logic [COIL_W-1:0] coil_lookup(input logic [PHASE_W-1:0] phase);
		logic [COIL_W-1:0] pat;
		unique case (phase)
			3'd0: pat = 4'h9;
			3'd1: pat = 4'h8;
			3'd2: pat = 4'hC;
			3'd3: pat = 4'h4;
			3'd4: pat = 4'h6;
			3'd5: pat = 4'h2;
			3'd6: pat = 4'h3;
			3'd7: pat = 4'h1;
			default: pat = 4'h0;
		endcase
		return pat;
	endfunction

endpackage

// ----- rtl/kass_step_conv.sv -----
module kass_step_conv import kass_pkg::*; (
	input  logic [ANGLE_W-1:0] angle,
	output logic [STEPS_W-1:0] steps
);

	// angle * 512 / 45 = 11 * angle + 17 * angle / 45
	localparam int REM_W  = ANGLE_W + 5;
	localparam int PROD_W = REM_W + RECIP_W;
	localparam int QUO_W  = ANGLE_W;
	localparam int SUM_W  = STEPS_W + 1;

	logic [REM_W-1:0]  rem_part;
	logic [PROD_W-1:0] prod;
	logic [QUO_W-1:0]  quo;
	logic [SUM_W-1:0]  whole_part;
	logic [SUM_W-1:0]  sum;

	// 17 * angle, then divide by 45 through the reciprocal
	assign rem_part = REM_W'({angle, 4'b0000}) + REM_W'(angle);
	assign prod     = PROD_W'(rem_part) * PROD_W'(RECIP_MULT);
	assign quo      = prod[RECIP_SHIFT +: QUO_W];

	// 11 * angle plus quotient, saturated to the step range
	assign whole_part = SUM_W'({angle, 3'b000}) + SUM_W'({angle, 1'b0}) + SUM_W'(angle);
	assign sum        = whole_part + SUM_W'(quo);
	assign steps      = sum[SUM_W-1] ? STEPS_MAX : sum[STEPS_W-1:0];

endmodule

// ----- rtl/keypad_angle_stepper_sequencer.sv -----
// channel  | group  | payload
// ---------+--------+-----------------------------------------------------------
// input    | s_axis | tdata: key_code[3:0], zero fill; tuser: req_type[0]
// output   | m_axis | tdata: coil_pattern[3:0], moving[4], steps_remaining[21:5]
//
// one result per input item, one item per cycle while the output is not stalled
// an item is held in the input register, then updates the state and the
// result register once the result register frees
// the hash conversion is one reciprocal multiply in that update path
// reset clears the valid flags and the sequencer state; the coil drive starts at zero
// a stalled result holds and the input register still takes one more item
module keypad_angle_stepper_sequencer import kass_pkg::*; #(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // key_code[3:0], zero fill
	input  logic [IN_USER_W-1:0]  s_axis_tuser,   // req_type[0]
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata    // coil_pattern, moving, steps_remaining
);

	localparam int               CNT_W       = $clog2(MAX_DIGITS + 1);
	localparam logic [CNT_W-1:0] DIGIT_LIMIT = CNT_W'(MAX_DIGITS);
	localparam int               ACC_W       = ANGLE_W + 4;
	localparam int               PAD_W       = OUT_DATA_W - STEPS_W - 1 - COIL_W;

	logic               valid_s1;
	req_type_t          req_s1;
	logic [KEY_W-1:0]   key_s1;
	logic               out_valid_q;
	logic               advance;
	logic               do_update;

	logic [ANGLE_W-1:0] angle_q, angle_n;
	logic [CNT_W-1:0]   digit_cnt_q, digit_cnt_n;
	logic               closed_q, closed_n;
	logic [STEPS_W-1:0] steps_q, steps_n;
	logic [PHASE_W-1:0] phase_q, phase_n;
	logic [COIL_W-1:0]  coil_q, coil_n;

	logic [ACC_W-1:0]   digit_acc;
	logic [STEPS_W-1:0] hash_steps;

	// handshake: the result register frees when empty or taken
	assign advance       = !out_valid_q || m_axis_tready;
	assign do_update     = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {PAD_W'(0), steps_q, (steps_q != '0), coil_q};

	// input and result register valid control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			req_s1 <= req_type_t'(s_axis_tuser[0]);
			key_s1 <= s_axis_tdata[KEY_W-1:0];
		end
	end

	// angle to half-step conversion
	kass_step_conv u_step_conv (
		.angle (angle_q),
		.steps (hash_steps)
	);

	// decimal accumulate of the next digit
	assign digit_acc = ACC_W'({angle_q, 3'b000}) + ACC_W'({angle_q, 1'b0}) + ACC_W'(key_s1);

	// next state for the item in the input register
	always_comb begin
		angle_n     = angle_q;
		digit_cnt_n = digit_cnt_q;
		closed_n    = closed_q;
		steps_n     = steps_q;
		phase_n     = phase_q;
		coil_n      = coil_q;
		if (do_update) begin
			unique case (req_s1)
				REQ_KEY: begin
					if (steps_q == '0) begin
						priority if (key_s1 <= KEY_DIGIT_MAX) begin
							if (!closed_q && digit_cnt_q < DIGIT_LIMIT) begin
								angle_n     = (digit_acc > ACC_W'(ANGLE_MAX)) ?
								              ANGLE_MAX : digit_acc[ANGLE_W-1:0];
								digit_cnt_n = digit_cnt_q + 1'b1;
							end
						end else if (key_s1 == KEY_STAR) begin
							closed_n = 1'b1;
						end else if (key_s1 == KEY_HASH) begin
							steps_n     = hash_steps;
							phase_n     = '0;
							angle_n     = '0;
							digit_cnt_n = '0;
							closed_n    = 1'b0;
						end else begin
							angle_n  = '0;
							closed_n = 1'b1;
						end
					end
				end
				REQ_TICK: begin
					if (steps_q != '0) begin
						coil_n  = coil_lookup(phase_q);
						steps_n = steps_q - 1'b1;
						phase_n = (steps_q == STEPS_W'(1)) ? '0 : phase_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// sequencer state, also the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q     <= '0;
			digit_cnt_q <= '0;
			closed_q    <= 1'b0;
			steps_q     <= '0;
			phase_q     <= '0;
			coil_q      <= '0;
		end else begin
			angle_q     <= angle_n;
			digit_cnt_q <= digit_cnt_n;
			closed_q    <= closed_n;
			steps_q     <= steps_n;
			phase_q     <= phase_n;
			coil_q      <= coil_n;
		end
	end

	// phase is back at the start whenever no move is running
	assert property (@(posedge clk) disable iff (!arst_n)
		steps_q == '0 |-> phase_q == '0)
		else $error("phase not reset while idle");

	// digit count never passes the limit
	assert property (@(posedge clk) disable iff (!arst_n)
		digit_cnt_q <= DIGIT_LIMIT)
		else $error("digit count beyond limit");

	// an empty result register never stalls the input
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_axis_tready)
		else $error("input stalled with empty result register");

	// state only moves when a result is produced
	assert property (@(posedge clk) disable iff (!arst_n)
		!do_update |=> $stable(steps_q) && $stable(coil_q) && $stable(angle_q))
		else $error("state changed without an item");

	// a tick during a move takes exactly one step
	assert property (@(posedge clk) disable iff (!arst_n)
		do_update && req_s1 == REQ_TICK && steps_q != '0 |=> steps_q == $past(steps_q) - 1'b1)
		else $error("tick did not count down one step");

endmodule
